/* src/rdtw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rdtw_pkg;

    localparam int unsigned DW         = 32;
    localparam int unsigned ACC_W      = 100;
    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned SQRT_STEPS = 32;

    localparam logic [31:0] EPS_RESET   = 32'd429497;
    localparam logic        REG_EPSILON = 1'b0;
    localparam logic [63:0] DIV_SEED    = 64'd16384;
    localparam logic [31:0] W_SAT       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [63:0] x;
        logic        tiny;
    } t_arg;

    typedef struct packed {
        logic [63:0] q;
        logic        tiny;
    } t_quot;

endpackage
`default_nettype wire

/* src/rdtw_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
interface rdtw_pix_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] j11;
    logic signed [31:0] j22;
    logic signed [31:0] j33;
    logic signed [31:0] j12;
    logic signed [31:0] j13;
    logic signed [31:0] j23;
    logic signed [31:0] du;
    logic signed [31:0] dv;

    modport source (output valid, j11, j22, j33, j12, j13, j23, du, dv, input ready);
    modport sink   (input valid, j11, j22, j33, j12, j13, j23, du, dv, output ready);
endinterface

interface rdtw_wt_if;
    logic        valid;
    logic        ready;
    logic [31:0] weight;

    modport source (output valid, weight, input ready);
    modport sink   (input valid, weight, output ready);
endinterface
`default_nettype wire

/* src/rdtw_form.sv */
`timescale 1ns / 1ps
`default_nettype none
module rdtw_form (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_j11,
    input  wire logic signed [31:0] i_j22,
    input  wire logic signed [31:0] i_j33,
    input  wire logic signed [31:0] i_j12,
    input  wire logic signed [31:0] i_j13,
    input  wire logic signed [31:0] i_j23,
    input  wire logic signed [31:0] i_du,
    input  wire logic signed [31:0] i_dv,
    input  wire logic        [31:0] i_eps,
    output logic                    o_valid,
    output rdtw_pkg::t_arg          o_arg
);
    import rdtw_pkg::*;

    logic [6:0] r_v;

    // stage 1: first products
    logic signed [63:0] r1_p11, r1_p22, r1_p12, r1_p13, r1_p23;
    logic signed [31:0] r1_du, r1_dv, r1_j33;
    // stage 2: split products
    logic signed [63:0] r2_h11, r2_h22, r2_h12;
    logic signed [64:0] r2_l11, r2_l22, r2_l12;
    logic signed [64:0] r2_lin;
    logic signed [31:0] r2_j33;
    // stage 3: cubic terms
    logic signed [ACC_W-1:0] r3_t11, r3_t22, r3_t12;
    logic signed [64:0]      r3_lin;
    logic signed [31:0]      r3_j33;
    // stage 4/5: sum
    logic signed [ACC_W-1:0] r4_a, r4_b, r4_c;
    logic signed [ACC_W-1:0] r5_s;
    // stage 6/7: clamp, epsilon
    logic [63:0] r6_qv;
    logic [63:0] r7_x;
    logic        r7_tiny;

    logic [64:0] n7_sum;
    logic [63:0] n7_x;

    assign n7_sum = {1'b0, r6_qv} + {33'd0, i_eps};
    assign n7_x   = n7_sum[64] ? '1 : n7_sum[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p11 <= 64'(i_j11) * 64'(i_du);
            r1_p22 <= 64'(i_j22) * 64'(i_dv);
            r1_p12 <= 64'(i_j12) * 64'(i_du);
            r1_p13 <= 64'(i_j13) * 64'(i_du);
            r1_p23 <= 64'(i_j23) * 64'(i_dv);
            r1_du  <= i_du;
            r1_dv  <= i_dv;
            r1_j33 <= i_j33;

            r2_h11 <= 64'($signed(r1_p11[63:32])) * 64'(r1_du);
            r2_h22 <= 64'($signed(r1_p22[63:32])) * 64'(r1_dv);
            r2_h12 <= 64'($signed(r1_p12[63:32])) * 64'(r1_dv);
            r2_l11 <= 65'($signed({1'b0, r1_p11[31:0]})) * 65'(r1_du);
            r2_l22 <= 65'($signed({1'b0, r1_p22[31:0]})) * 65'(r1_dv);
            r2_l12 <= 65'($signed({1'b0, r1_p12[31:0]})) * 65'(r1_dv);
            r2_lin <= 65'(r1_p13) + 65'(r1_p23);
            r2_j33 <= r1_j33;

            r3_t11 <= (ACC_W'(r2_h11) <<< 32) + ACC_W'(r2_l11);
            r3_t22 <= (ACC_W'(r2_h22) <<< 32) + ACC_W'(r2_l22);
            r3_t12 <= (ACC_W'(r2_h12) <<< 32) + ACC_W'(r2_l12);
            r3_lin <= r2_lin;
            r3_j33 <= r2_j33;

            r4_a <= r3_t11 + r3_t22;
            r4_b <= (r3_t12 <<< 1) + (ACC_W'(r3_j33) <<< 32);
            r4_c <= ACC_W'(r3_lin) <<< 17;

            r5_s <= r4_a + r4_b + r4_c;

            if (r5_s[ACC_W-1]) begin
                r6_qv <= '0;
            end else if (|r5_s[ACC_W-2:80]) begin
                r6_qv <= '1;
            end else begin
                r6_qv <= r5_s[79:16];
            end

            r7_x    <= n7_x;
            r7_tiny <= (n7_x[63:15] == '0) && (!n7_x[14] || (n7_x[13:0] == '0));
        end
    end

    assign o_valid    = r_v[6];
    assign o_arg.x    = r7_x;
    assign o_arg.tiny = r7_tiny;

endmodule
`default_nettype wire

/* src/rdtw_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module rdtw_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  rdtw_pkg::t_arg      i_arg,
    output logic                o_valid,
    output rdtw_pkg::t_quot     o_quot
);
    import rdtw_pkg::*;

    logic [63:0] c_rem  [DIV_STEPS];
    logic [63:0] c_q    [DIV_STEPS];
    logic [63:0] c_x    [DIV_STEPS];
    logic        c_tiny [DIV_STEPS];
    logic        c_v    [DIV_STEPS];

    logic [63:0] r_rem  [DIV_STEPS];
    logic [63:0] r_q    [DIV_STEPS];
    logic [63:0] r_x    [DIV_STEPS];
    logic        r_tiny [DIV_STEPS];
    logic        r_v    [DIV_STEPS];

    // one quotient bit per stage, 2^78 / x starting from remainder 2^14
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [64:0] w_sh;
        logic [64:0] w_df;
        logic        w_ge;

        if (k == 0) begin : g_head
            assign c_rem[k]  = DIV_SEED;
            assign c_q[k]    = '0;
            assign c_x[k]    = i_arg.x;
            assign c_tiny[k] = i_arg.tiny;
            assign c_v[k]    = i_valid;
        end else begin : g_link
            assign c_rem[k]  = r_rem[k-1];
            assign c_q[k]    = r_q[k-1];
            assign c_x[k]    = r_x[k-1];
            assign c_tiny[k] = r_tiny[k-1];
            assign c_v[k]    = r_v[k-1];
        end

        assign w_sh = {c_rem[k], 1'b0};
        assign w_df = w_sh - {1'b0, c_x[k]};
        assign w_ge = w_sh >= {1'b0, c_x[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_df[63:0] : w_sh[63:0];
                r_q[k]    <= {c_q[k][62:0], w_ge};
                r_x[k]    <= c_x[k];
                r_tiny[k] <= c_tiny[k];
            end
        end
    end

    assign o_valid     = r_v[DIV_STEPS-1];
    assign o_quot.q    = r_q[DIV_STEPS-1];
    assign o_quot.tiny = r_tiny[DIV_STEPS-1];

endmodule
`default_nettype wire

/* src/rdtw_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module rdtw_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  rdtw_pkg::t_quot     i_quot,
    output logic                o_valid,
    output logic [31:0]         o_weight
);
    import rdtw_pkg::*;

    logic [63:0] c_y    [SQRT_STEPS];
    logic [63:0] c_res  [SQRT_STEPS];
    logic        c_tiny [SQRT_STEPS];
    logic        c_v    [SQRT_STEPS];

    logic [63:0] r_y    [SQRT_STEPS];
    logic [63:0] r_res  [SQRT_STEPS];
    logic        r_tiny [SQRT_STEPS];
    logic        r_v    [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_t;
        logic        w_ge;

        if (k == 0) begin : g_head
            assign c_y[k]    = i_quot.q;
            assign c_res[k]  = '0;
            assign c_tiny[k] = i_quot.tiny;
            assign c_v[k]    = i_valid;
        end else begin : g_link
            assign c_y[k]    = r_y[k-1];
            assign c_res[k]  = r_res[k-1];
            assign c_tiny[k] = r_tiny[k-1];
            assign c_v[k]    = r_v[k-1];
        end

        assign w_t  = c_res[k] + BIT;
        assign w_ge = c_y[k] >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[k]    <= w_ge ? c_y[k] - w_t : c_y[k];
                r_res[k]  <= w_ge ? (c_res[k] >> 1) + BIT : c_res[k] >> 1;
                r_tiny[k] <= c_tiny[k];
            end
        end
    end

    assign o_valid  = r_v[SQRT_STEPS-1];
    assign o_weight = r_tiny[SQRT_STEPS-1] ? W_SAT : r_res[SQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

/* src/robust_data_term_weight_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                               transfer
// i_pix     in   j11 j22 j33 j12 j13 j23 du dv (s32)    valid & ready
// o_wt      out  weight (u32, Q9.23)                    valid & ready
// apb       in   epsilon at byte address 0              psel & penable & pwrite
//
// One pixel per cycle while the pipeline is not held; 7 form stages, 64 divider
// stages, 32 square-root stages, output register.
// Reset clears valid bits and sets epsilon to its default.
// A two-entry output buffer takes the last result of a stalled sink; the
// whole pipeline holds only while that buffer is full.
module robust_data_term_weight_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rdtw_pix_if.sink         i_pix,
    rdtw_wt_if.source        o_wt,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);
    import rdtw_pkg::*;

    logic [31:0] r_eps;
    logic        w_en;

    logic  w_form_v;
    t_arg  w_arg;
    logic  w_div_v;
    t_quot w_quot;
    logic        w_sq_v;
    logic [31:0] w_sq_w;

    logic        r_out_v;
    logic [31:0] r_out_w;
    logic        r_sk_v;
    logic [31:0] r_sk_w;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_EPSILON) ? r_eps : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_EPSILON)) begin
            r_eps <= i_pwdata;
        end
    end

    assign w_en        = !r_sk_v;
    assign i_pix.ready = w_en;

    rdtw_form u_form (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pix.valid),
        .i_j11   (i_pix.j11),
        .i_j22   (i_pix.j22),
        .i_j33   (i_pix.j33),
        .i_j12   (i_pix.j12),
        .i_j13   (i_pix.j13),
        .i_j23   (i_pix.j23),
        .i_du    (i_pix.du),
        .i_dv    (i_pix.dv),
        .i_eps   (r_eps),
        .o_valid (w_form_v),
        .o_arg   (w_arg)
    );

    rdtw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_form_v),
        .i_arg   (w_arg),
        .o_valid (w_div_v),
        .o_quot  (w_quot)
    );

    rdtw_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_div_v),
        .i_quot   (w_quot),
        .o_valid  (w_sq_v),
        .o_weight (w_sq_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_out_v || o_wt.ready) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= w_sq_v;
            end
        end else if (w_en && w_sq_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_wt.ready) begin
            r_out_w <= r_sk_v ? r_sk_w : w_sq_w;
        end else if (w_en && w_sq_v) begin
            r_sk_w <= w_sq_w;
        end
    end

    assign o_wt.valid  = r_out_v;
    assign o_wt.weight = r_out_w;

endmodule
`default_nettype wire

/* verif/robust_data_term_weight_core_test.sv */
`timescale 1ns / 1ps
module robust_data_term_weight_core_test;
    import rdtw_pkg::*;

    typedef struct {
        logic signed [31:0] j11, j22, j33, j12, j13, j23, du, dv;
    } t_pix;

    typedef struct {
        t_pix        pix;
        logic        known;
        logic [31:0] wt;
    } t_row;

    localparam int LATENCY   = 104;
    localparam int WDOG_MAX  = 20000;
    localparam int RAND_ITEMS = 450;
    localparam logic [2:0] ADDR_EPSILON = 3'd0;

    logic i_clk;
    logic i_rst_n;
    logic i_psel, i_penable, i_pwrite;
    logic [2:0] i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic o_pready;

    rdtw_pix_if pix_if ();
    rdtw_wt_if  wt_if ();

    robust_data_term_weight_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pix(pix_if.sink), .o_wt(wt_if.source),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata),
        .o_prdata(o_prdata), .o_pready(o_pready)
    );

    logic [31:0] eps_cur;
    logic [31:0] weight_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_recv;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // exact floor(sqrt(y))
    function automatic logic [63:0] isqrt(logic [127:0] y);
        logic [127:0] res;
        logic [127:0] bitv;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > y) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (y >= res + bitv) begin
                y   = y - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[63:0];
    endfunction

    function automatic logic [31:0] penalty_weight(t_pix p, logic [31:0] eps);
        logic signed [127:0] s;
        logic signed [127:0] a11, a22, a33, a12, a13, a23, u, v;
        logic [63:0]  qv;
        logic [64:0]  xs;
        logic [63:0]  x;
        logic [127:0] quo;
        logic [63:0]  w;
        a11 = p.j11; a22 = p.j22; a33 = p.j33;
        a12 = p.j12; a13 = p.j13; a23 = p.j23;
        u = p.du; v = p.dv;
        s = a11 * u * u + a22 * v * v + (a33 <<< 32) + 2 * a12 * u * v
            + ((2 * a13 * u) <<< 16) + ((2 * a23 * v) <<< 16);
        if (s < 0)
            qv = '0;
        else if (s[127:80] != 0)
            qv = '1;
        else
            qv = s[79:16];
        xs = {1'b0, qv} + {33'd0, eps};
        x  = xs[64] ? '1 : xs[63:0];
        if (x <= 64'd16384)
            return W_SAT;
        quo = (128'd1 << 78) / x;
        w = isqrt(quo);
        return (w > 64'hFFFF_FFFF) ? W_SAT : w[31:0];
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        i_psel = 1'b1; i_penable = 1'b0; i_pwrite = 1'b1;
        i_paddr = addr; i_pwdata = data;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        @(negedge i_clk);
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0;
        if (addr == ADDR_EPSILON) eps_cur = data;
    endtask

    task automatic send_pix(t_pix p, logic known, logic [31:0] wt);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge i_clk);
        pix_if.valid = 1'b1;
        pix_if.j11 = p.j11; pix_if.j22 = p.j22; pix_if.j33 = p.j33;
        pix_if.j12 = p.j12; pix_if.j13 = p.j13; pix_if.j23 = p.j23;
        pix_if.du = p.du; pix_if.dv = p.dv;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        if (known && wt != penalty_weight(p, eps_cur)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row weight %h disagrees with predictor %h",
                         wt, penalty_weight(p, eps_cur));
        end
        weight_q.push_back(penalty_weight(p, eps_cur));
        @(negedge i_clk);
        pix_if.valid = 1'b0;
    endtask

    task automatic drain;
        while (weight_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_field();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(65536 * 4) - 65536 * 2;
            2: return {{16{1'b0}}, 16'($urandom())};
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(1024) - 512;
        endcase
    endfunction

    function automatic t_pix rnd_pix();
        t_pix p;
        p.j11 = rnd_field(); p.j22 = rnd_field(); p.j33 = rnd_field();
        p.j12 = rnd_field(); p.j13 = rnd_field(); p.j23 = rnd_field();
        p.du  = rnd_field(); p.dv  = rnd_field();
        if ($urandom_range(3) == 0) begin
            p.du = $urandom_range(4096) - 2048;
            p.dv = $urandom_range(4096) - 2048;
        end
        return p;
    endfunction

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_recv)
            wt_if.ready <= 1'b0;
        else
            wt_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (wt_if.valid && wt_if.ready) begin
                if (weight_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected weight %h", wt_if.weight);
                end else begin
                    if (wt_if.weight !== weight_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("weight mismatch: expected %h actual %h",
                                     weight_q[0], wt_if.weight);
                    end
                    void'(weight_q.pop_front());
                end
            end
            if ((wt_if.valid && wt_if.ready) || (pix_if.valid && pix_if.ready)
                || hold_recv)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stim
        t_row rows[$];
        t_row r;
        t_pix z;
        int   n;
        i_rst_n = 1'b0;
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0;
        i_paddr = '0; i_pwdata = '0;
        pix_if.valid = 1'b0;
        {pix_if.j11, pix_if.j22, pix_if.j33, pix_if.j12} = '0;
        {pix_if.j13, pix_if.j23, pix_if.du, pix_if.dv} = '0;
        wt_if.ready = 1'b0;
        eps_cur = EPS_RESET;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        z = '{default: 32'sd0};
        // zero form, reset epsilon: floor(sqrt(2^78/429497))
        r.pix = z; r.known = 1'b1; r.wt = 32'd838860535; rows.push_back(r);
        // q = 1.0 exactly through j33
        r.pix = z; r.pix.j33 = 32'sh0001_0000; r.known = 1'b0; rows.push_back(r);
        // negative form clamps to zero
        r.pix = z; r.pix.j33 = 32'sh8000_0000; r.known = 1'b1; r.wt = 32'd838860535;
        rows.push_back(r);
        r.pix = z; r.pix.j33 = 32'sh7FFF_FFFF; r.known = 1'b0; rows.push_back(r);
        // extreme inputs: the form saturates at the top or clamps to zero
        r.pix = '{default: 32'sh7FFF_FFFF}; r.known = 1'b0; rows.push_back(r);
        r.pix = '{default: 32'sh8000_0000}; r.known = 1'b0; rows.push_back(r);
        r.pix = z; r.pix.j11 = 32'sh7FFF_FFFF; r.pix.du = 32'sh8000_0000;
        r.known = 1'b0; rows.push_back(r);
        r.pix = z; r.pix.j22 = 32'sh8000_0000; r.pix.dv = 32'sh7FFF_FFFF;
        r.known = 1'b1; r.wt = 32'd838860535; rows.push_back(r);
        r.pix = z; r.pix.j12 = 32'sh0001_0000; r.pix.du = 32'sh0002_0000;
        r.pix.dv = 32'shFFFF_0000; r.known = 1'b0; rows.push_back(r);
        r.pix = z; r.pix.j13 = 32'sh7FFF_FFFF; r.pix.du = 32'sh0000_0001;
        r.known = 1'b0; rows.push_back(r);
        r.pix = z; r.pix.j23 = 32'sh0000_8000; r.pix.dv = 32'sh0001_0000;
        r.known = 1'b0; rows.push_back(r);
        r.pix = '{default: 32'shFFFF_FFFF}; r.known = 1'b0; rows.push_back(r);
        foreach (rows[i]) send_pix(rows[i].pix, rows[i].known, rows[i].wt);
        drain();

        // tiny argument saturates, then the largest epsilon
        apb_write(ADDR_EPSILON, 32'd0);
        send_pix(z, 1'b1, W_SAT);
        r.pix = z; r.pix.j33 = 32'sh0000_0001; send_pix(r.pix, 1'b0, '0);
        drain();
        apb_write(ADDR_EPSILON, 32'hFFFF_FFFF);
        send_pix(z, 1'b0, '0);
        send_pix('{default: 32'sh7FFF_FFFF}, 1'b1, 32'd128);
        drain();
        apb_write(ADDR_EPSILON, 32'd1);
        send_pix(z, 1'b1, W_SAT);
        drain();

        // random phases: none, sender idle, receiver stall, both
        n = 0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 72 : (ph == 3) ? 10 : 0;
            recv_stall_pct = (ph == 2) ? 72 : (ph == 3) ? 10 : 0;
            apb_write(ADDR_EPSILON, (ph == 0) ? EPS_RESET :
                      (ph == 1) ? $urandom() : (ph == 2) ? 32'd16385 : 32'hFFFF_FFFF);
            if (ph == 2) begin
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < RAND_ITEMS / 4; k++) begin
                send_pix(rnd_pix(), 1'b0, '0);
                n++;
            end
            // sender pauses until everything is back
            drain();
        end

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/rdtw_pkg.sv
src/rdtw_ifs.sv
src/rdtw_form.sv
src/rdtw_div.sv
src/rdtw_sqrt.sv
src/robust_data_term_weight_core.sv
verif/robust_data_term_weight_core_test.sv
